// ----- rtl/core/ldd_pkg.sv -----
// Shared types and field layout of the lock deadlock detector.
`timescale 1ns / 1ps

package ldd_pkg;

	// Input transaction fields.
	localparam int MODE_W   = 2;
	localparam int THREAD_W = 4;
	localparam int RES_W    = 3;
	localparam int CNT_W    = 8;
	localparam int STATUS_W = 2;

	// Bit positions inside s_tdata, lowest field first.
	localparam int THREAD_LO = 0;
	localparam int RES_LO    = THREAD_LO + THREAD_W;
	localparam int CNT_LO    = RES_LO + RES_W;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_CREATE  = 2'd0,
		MODE_REQUEST = 2'd1,
		MODE_GRANT   = 2'd2,
		MODE_RELEASE = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_DEADLOCK = 2'd2
	} status_t;

endpackage

// ----- rtl/core/ldd_matrix.sv -----
// Per-thread row store of held counts and waiting flags, with row valid bits.
`timescale 1ns / 1ps

module ldd_matrix #(
	parameter int THREADS = 16,
	parameter int ROW_W   = 72
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [$clog2(THREADS)-1:0] rd_addr,
	output logic [ROW_W-1:0]           rd_row,
	input  logic                       wr_en,
	input  logic [$clog2(THREADS)-1:0] wr_addr,
	input  logic [ROW_W-1:0]           wr_row
);

	logic [ROW_W-1:0] mem_q [THREADS];
	logic [THREADS-1:0] vld_q;
	logic [ROW_W-1:0] rd_data_q;
	logic rd_ok_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// A row that was never written reads as all zero, which is its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_row = rd_ok_q ? rd_data_q : '0;

endmodule

// ----- rtl/core/lock_deadlock_detector.sv -----
// Top level of the lock deadlock detector: sequencer, free counts and detection unit.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// s        in         s_tvalid / s_tready  s_tuser: mode; s_tdata: thread, resource, count
// m        out        m_tvalid / m_tready  m_tdata: status
// cfg      in         cfg_we               cfg_wdata: detect_enable
//
// Each input transaction is handled on its own while s_tready is low. A rejected id
// goes straight to the done state; a request without detection, a grant or a release
// pass through the read, modify and done states; and a create sweeps the thread store,
// one row of the thread store a cycle. A request with detection repeats detection passes
// and at most THREADS + 1 passes run, so the row store read port sets the rate.
// Reset is asynchronous and clears all counts, flags and valid bits at once.
// A finished result waits in the output register; a new transaction is accepted
// meanwhile, and the block only holds in its final state if the result register is
// still occupied when the next result is ready.

module lock_deadlock_detector #(
	parameter int THREADS    = 16,
	parameter int RESOURCES  = 8,
	parameter int COUNT_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tuser: mode [1:0]
	input  logic [ldd_pkg::MODE_W-1:0]      s_tuser,
	// s_tdata: thread [3:0], resource [6:4], count [14:7], zero [15]
	input  logic [ldd_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata: status [1:0], zero [7:2]
	output logic [ldd_pkg::M_TDATA_W-1:0]   m_tdata
);

	import ldd_pkg::*;

	localparam int TW      = $clog2(THREADS);
	localparam int IW      = $clog2(THREADS + 1);
	localparam int RIW     = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
	localparam int WAIT_LO = RESOURCES * COUNT_BITS;
	localparam int ROW_W   = RESOURCES * (COUNT_BITS + 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [IW-1:0] IDX_END = IW'(THREADS);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RD    = 7'b0000010,
		S_MOD   = 7'b0000100,
		S_SWEEP = 7'b0001000,
		S_DET   = 7'b0010000,
		S_FIN   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	// Control and configuration.
	logic detect_en_q;
	logic m_tvalid_q;
	status_t m_status_q;
	status_t status_q;
	logic [IW-1:0] idx_q;
	logic ev_v_s1;

	// Resource state held in flip-flops.
	logic [COUNT_BITS-1:0] free_q [RESOURCES];
	logic [RESOURCES-1:0] res_valid_q;

	// Latched transaction and detection scratch.
	mode_t mode_q;
	logic [TW-1:0] thr_q;
	logic [RIW-1:0] res_q;
	logic [TW-1:0] ev_idx_s1;
	logic [ROW_W-1:0] row_q;
	logic [RESOURCES-1:0] work_q;
	logic [THREADS-1:0] fin_q;
	logic chg_q;

	// Row store interface.
	logic rd_en;
	logic [TW-1:0] rd_addr;
	logic [ROW_W-1:0] rd_row;
	logic wr_en;
	logic [TW-1:0] wr_addr;
	logic [ROW_W-1:0] wr_row;

	// Incoming transaction decode.
	logic s_accept;
	mode_t in_mode;
	logic [THREAD_W-1:0] in_thr;
	logic [RES_W-1:0] in_res;
	logic [CNT_W-1:0] in_cnt;
	logic [RIW-1:0] in_res_idx;
	logic id_ok;
	logic [COUNT_BITS-1:0] cnt_sat;

	// Row arithmetic.
	logic [COUNT_BITS-1:0] held_cur;
	logic [COUNT_BITS-1:0] free_cur;
	logic [COUNT_BITS-1:0] free_nxt;
	logic [ROW_W-1:0] mod_row;
	logic [ROW_W-1:0] clr_row;
	logic [ROW_W-1:0] wdraw_row;
	logic [RESOURCES-1:0] held_nz;
	logic [RESOURCES-1:0] wait_bits;
	logic [RESOURCES-1:0] free_nz;
	logic fits;
	logic pass_end;
	logic deadlock;

	assign in_mode    = mode_t'(s_tuser);
	assign in_thr     = s_tdata[THREAD_LO +: THREAD_W];
	assign in_res     = s_tdata[RES_LO +: RES_W];
	assign in_cnt     = s_tdata[CNT_LO +: CNT_W];
	assign in_res_idx = RIW'(in_res);

	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid && s_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(m_status_q);

	// Out-of-range ids are rejected for every mode; an uncreated resource for all but create.
	always_comb begin
		id_ok = (32'(in_thr) < 32'(THREADS)) && (32'(in_res) < 32'(RESOURCES));
		if (in_mode != MODE_CREATE) begin
			id_ok = id_ok && res_valid_q[in_res_idx];
		end
	end

	assign cnt_sat = (32'(in_cnt) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(in_cnt);

	// Read-modify-write of the addressed entry for request, grant and release.
	always_comb begin
		held_cur = rd_row[res_q*COUNT_BITS +: COUNT_BITS];
		free_cur = free_q[res_q];
		free_nxt = free_cur;
		mod_row  = rd_row;
		case (mode_q)
			MODE_REQUEST: begin
				mod_row[WAIT_LO + res_q] = 1'b1;
			end
			MODE_GRANT: begin
				mod_row[WAIT_LO + res_q] = 1'b0;
				if (held_cur != COUNT_MAX) begin
					mod_row[res_q*COUNT_BITS +: COUNT_BITS] = held_cur + COUNT_BITS'(1);
				end
				if (free_cur != '0) begin
					free_nxt = free_cur - COUNT_BITS'(1);
				end
			end
			MODE_RELEASE: begin
				if (held_cur != '0) begin
					mod_row[res_q*COUNT_BITS +: COUNT_BITS] = held_cur - COUNT_BITS'(1);
					if (free_cur != COUNT_MAX) begin
						free_nxt = free_cur + COUNT_BITS'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Create clears the resource's column in every row; a deadlock withdraws the request.
	always_comb begin
		clr_row = rd_row;
		clr_row[res_q*COUNT_BITS +: COUNT_BITS] = '0;
		clr_row[WAIT_LO + res_q] = 1'b0;
		wdraw_row = row_q;
		wdraw_row[WAIT_LO + res_q] = 1'b0;
	end

	// The detection unit only needs to know whether a work entry is nonzero: entries
	// start at the free count and only grow, so one bit per resource carries them.
	always_comb begin
		for (int r = 0; r < RESOURCES; r++) begin
			held_nz[r]   = (rd_row[r*COUNT_BITS +: COUNT_BITS] != '0);
			wait_bits[r] = rd_row[WAIT_LO + r];
			free_nz[r]   = (free_q[r] != '0);
		end
		fits = ((wait_bits & ~work_q) == '0);
	end

	assign pass_end = (idx_q == IDX_END) && !ev_v_s1;
	assign deadlock = !(&fin_q);

	// Row store port selection per state.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = thr_q;
		wr_en   = 1'b0;
		wr_addr = thr_q;
		wr_row  = mod_row;
		unique case (state_q)
			S_RD: begin
				rd_en = 1'b1;
			end
			S_MOD: begin
				wr_en = 1'b1;
			end
			S_SWEEP: begin
				rd_en   = (idx_q != IDX_END);
				rd_addr = idx_q[TW-1:0];
				wr_en   = ev_v_s1;
				wr_addr = ev_idx_s1;
				wr_row  = clr_row;
			end
			S_DET: begin
				rd_en   = (idx_q != IDX_END);
				rd_addr = idx_q[TW-1:0];
			end
			S_FIN: begin
				wr_en  = deadlock;
				wr_row = wdraw_row;
			end
			S_IDLE, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	ldd_matrix #(
		.THREADS (THREADS),
		.ROW_W   (ROW_W)
	) u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_row  (rd_row),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_row  (wr_row)
	);

	// Sequencer, free counts and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			detect_en_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_status_q  <= ST_OK;
			status_q    <= ST_OK;
			idx_q       <= '0;
			ev_v_s1     <= 1'b0;
			res_valid_q <= '0;
			for (int r = 0; r < RESOURCES; r++) begin
				free_q[r] <= '0;
			end
		end else begin
			if (cfg_we) begin
				detect_en_q <= cfg_wdata;
			end
			// The result register loads from the done state and empties on a handshake.
			if ((state_q == S_DONE) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			ev_v_s1 <= rd_en && ((state_q == S_SWEEP) || (state_q == S_DET));
			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						if (!id_ok) begin
							status_q <= ST_INVALID;
							state_q  <= S_DONE;
						end else if (in_mode == MODE_CREATE) begin
							free_q[in_res_idx]      <= cnt_sat;
							res_valid_q[in_res_idx] <= 1'b1;
							idx_q   <= '0;
							state_q <= S_SWEEP;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					free_q[res_q] <= free_nxt;
					status_q      <= ST_OK;
					if ((mode_q == MODE_REQUEST) && detect_en_q) begin
						idx_q   <= '0;
						state_q <= S_DET;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SWEEP, S_DET: begin
					if (rd_en) begin
						idx_q <= idx_q + IW'(1);
					end
					if (pass_end) begin
						if (state_q == S_SWEEP) begin
							status_q <= ST_OK;
							state_q  <= S_DONE;
						end else if (chg_q) begin
							idx_q <= '0;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					status_q <= deadlock ? ST_DEADLOCK : ST_OK;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_status_q <= status_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Transaction fields and detection scratch.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			mode_q <= in_mode;
			thr_q  <= TW'(in_thr);
			res_q  <= in_res_idx;
		end
		ev_idx_s1 <= idx_q[TW-1:0];
		if (state_q == S_MOD) begin
			row_q  <= mod_row;
			work_q <= free_nz;
			fin_q  <= '0;
			chg_q  <= 1'b0;
		end
		if (state_q == S_DET) begin
			// A thread whose waits all fit finishes and returns its holdings.
			if (ev_v_s1 && !fin_q[ev_idx_s1] && fits) begin
				work_q           <= work_q | held_nz;
				fin_q[ev_idx_s1] <= 1'b1;
				chg_q            <= 1'b1;
			end else if (pass_end) begin
				chg_q <= 1'b0;
			end
		end
	end

endmodule
